// ===== src/bmg_pkg.sv =====
// Shared types and constants for the Box-Muller Gaussian transform pipeline.
package bmg_pkg;

    localparam int UNIFORM_BITS = 32;
    localparam int FRAC_BITS    = 16;
    localparam int OUT_W        = FRAC_BITS + 4;

    // log2 by repeated squaring
    localparam int X_W       = UNIFORM_BITS + 1;
    localparam int P_W       = $clog2(X_W);
    localparam int MANT_W    = 32;
    localparam int LOG_FRAC  = 24;
    localparam int LOG_STEPS = LOG_FRAC;
    localparam int K_W       = $clog2(UNIFORM_BITS + 1);
    localparam int N_W       = LOG_FRAC + K_W;
    localparam logic [31:0] TWO_LN2_Q31 = 32'hB17217F8;
    localparam int S_W       = N_W + 32 - 7;

    // digit-by-digit square root, two bits of the radicand per cell
    localparam int SQRT_STEPS = (S_W + 1) / 2;
    localparam int V_W        = 2 * SQRT_STEPS;
    localparam int R_W        = SQRT_STEPS;
    localparam int REM_W      = R_W + 2;

    // trig, Q.30
    localparam int Q_W    = 30;
    localparam int TRIG_W = Q_W + 1;
    localparam logic [TRIG_W-1:0] ONE_Q30     = TRIG_W'(1) << Q_W;
    localparam logic [30:0]       HALF_PI_Q30 = 31'd1686629713;
    localparam int HORNER_STEPS = 5;
    localparam int SH_W         = 6;

    // output scaling
    localparam int PROD_W   = R_W + TRIG_W;
    localparam int ROUND_SH = 54 - FRAC_BITS;
    localparam int MAG_W    = PROD_W + 1 - ROUND_SH;
    localparam logic [MAG_W-1:0] SAT_LIM = MAG_W'(1) << (FRAC_BITS + 3);

    localparam logic [63:0] ONE64 = 64'd1;

    typedef struct packed {
        logic [31:0] ph;
        logic        last;
    } side_t;

    typedef struct packed {
        logic [MANT_W-1:0]   m;
        logic [LOG_FRAC-1:0] frac;
        logic [K_W-1:0]      k;
    } log_t;

    typedef struct packed {
        logic [V_W-1:0]   v;
        logic [REM_W-1:0] rem;
        logic [R_W-1:0]   root;
    } sqrt_t;

    typedef struct packed {
        logic [Q_W-1:0] th;
        logic [Q_W-1:0] t2;
        logic [1:0]     quad;
        logic           swap;
        logic [R_W-1:0] r;
        logic           last;
    } ang_t;

    typedef struct packed {
        logic [TRIG_W-1:0] s;
        logic [TRIG_W-1:0] c;
    } trig_t;

    // reciprocal multipliers: floor(y / k) = (y * m) >> sh for y < 2^30
    typedef struct packed {
        logic [31:0]     m_sin;
        logic [SH_W-1:0] sh_sin;
        logic [31:0]     m_cos;
        logic [SH_W-1:0] sh_cos;
    } horner_k_t;

    localparam horner_k_t HORNER_K [HORNER_STEPS] = '{
        '{32'(((ONE64 << 37) + 64'd109) / 64'd110), 6'd37,
          32'(((ONE64 << 37) + 64'd89) / 64'd90),   6'd37},
        '{32'(((ONE64 << 37) + 64'd71) / 64'd72),   6'd37,
          32'(((ONE64 << 36) + 64'd55) / 64'd56),   6'd36},
        '{32'(((ONE64 << 36) + 64'd41) / 64'd42),   6'd36,
          32'(((ONE64 << 35) + 64'd29) / 64'd30),   6'd35},
        '{32'(((ONE64 << 35) + 64'd19) / 64'd20),   6'd35,
          32'(((ONE64 << 34) + 64'd11) / 64'd12),   6'd34},
        '{32'(((ONE64 << 33) + 64'd5) / 64'd6),     6'd33,
          32'(((ONE64 << 31) + 64'd1) / 64'd2),     6'd31}
    };

endpackage

// ===== src/bmg_log_cell.sv =====
// One squaring step of the log2 chain: yields one fraction bit per cell.
module bmg_log_cell import bmg_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  src_valid,
    input  log_t  src_log,
    input  side_t src_side,
    output logic  dst_valid,
    output log_t  dst_log,
    output side_t dst_side
);

    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sh;
    logic                carry;
    log_t                log_next;
    logic                valid_reg;
    log_t                log_reg;
    side_t               side_reg;

    always_comb
    begin
        sq             = {{MANT_W{1'b0}}, src_log.m} * {{MANT_W{1'b0}}, src_log.m};
        sh             = sq[2*MANT_W-1:MANT_W-1];
        carry          = sh[MANT_W];
        log_next.m     = carry ? sh[MANT_W:1] : sh[MANT_W-1:0];
        log_next.frac  = {src_log.frac[LOG_FRAC-2:0], carry};
        log_next.k     = src_log.k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            log_reg  <= log_next;
            side_reg <= src_side;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_log   = log_reg;
    assign dst_side  = side_reg;

`ifndef ASSERT_OFF
    // mantissa stays normalised to [1,2)
    a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> dst_log.m[MANT_W-1])
        else $error("log mantissa lost normalisation");
`endif

endmodule

// ===== src/bmg_sqrt_cell.sv =====
// One restoring square-root step: consumes two radicand bits, yields one root bit.
module bmg_sqrt_cell import bmg_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  src_valid,
    input  sqrt_t src_sqrt,
    input  side_t src_side,
    output logic  dst_valid,
    output sqrt_t dst_sqrt,
    output side_t dst_side
);

    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    sqrt_t            sqrt_next;
    logic             valid_reg;
    sqrt_t            sqrt_reg;
    side_t            side_reg;

    always_comb
    begin
        rem2        = {src_sqrt.rem[REM_W-3:0], src_sqrt.v[V_W-1:V_W-2]};
        trial       = {src_sqrt.root, 2'b01};
        sqrt_next.v = {src_sqrt.v[V_W-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            sqrt_next.rem  = rem2 - trial;
            sqrt_next.root = {src_sqrt.root[R_W-2:0], 1'b1};
        end
        else
        begin
            sqrt_next.rem  = rem2;
            sqrt_next.root = {src_sqrt.root[R_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqrt_reg <= sqrt_next;
            side_reg <= src_side;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_sqrt  = sqrt_reg;
    assign dst_side  = side_reg;

`ifndef ASSERT_OFF
    // partial remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (dst_sqrt.rem <= REM_W'({dst_sqrt.root, 1'b0})))
        else $error("sqrt remainder out of bound");
`endif

endmodule

// ===== src/bmg_horner_cell.sv =====
// One Horner step for the sine and cosine lanes, two register stages.
module bmg_horner_cell import bmg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  horner_k_t coef,
    input  logic      src_valid,
    input  ang_t      src_ang,
    input  trig_t     src_trig,
    output logic      dst_valid,
    output ang_t      dst_ang,
    output trig_t     dst_trig
);

    logic [Q_W+TRIG_W-1:0] prod_s;
    logic [Q_W+TRIG_W-1:0] prod_c;
    logic [Q_W+31:0]       quo_s;
    logic [Q_W+31:0]       quo_c;
    trig_t                 trig_next;

    logic           mid_valid_reg;
    ang_t           mid_ang_reg;
    logic [Q_W-1:0] ps_reg;
    logic [Q_W-1:0] pc_reg;
    logic           valid_reg;
    ang_t           ang_reg;
    trig_t          trig_reg;

    always_comb
    begin
        prod_s      = src_ang.t2 * src_trig.s;
        prod_c      = src_ang.t2 * src_trig.c;
        quo_s       = (ps_reg * coef.m_sin) >> coef.sh_sin;
        quo_c       = (pc_reg * coef.m_cos) >> coef.sh_cos;
        trig_next.s = ONE_Q30 - quo_s[TRIG_W-1:0];
        trig_next.c = ONE_Q30 - quo_c[TRIG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (adv)
        begin
            mid_valid_reg <= src_valid;
            valid_reg     <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mid_ang_reg <= src_ang;
            ps_reg      <= prod_s[2*Q_W-1:Q_W];
            pc_reg      <= prod_c[2*Q_W-1:Q_W];
            ang_reg     <= mid_ang_reg;
            trig_reg    <= trig_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_ang   = ang_reg;
    assign dst_trig  = trig_reg;

`ifndef ASSERT_OFF
    a_trig_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (dst_trig.s <= ONE_Q30 && dst_trig.c <= ONE_Q30))
        else $error("Horner accumulator above one");
`endif

endmodule

// ===== src/box_muller_gaussian_transform_unit.sv =====
// Box-Muller Gaussian transform: top level, log / sqrt / trig chains of cells.
// Throughput: one beat per cycle; the chain moves as a whole and halts only
// while the output register holds a beat that is stalled.
// Reset: rst_n clears every valid bit asynchronously; the data path needs none.
module box_muller_gaussian_transform_unit import bmg_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    uni_valid,
    output logic                    uni_stall,
    input  logic [31:0]             u_radius,
    input  logic [31:0]             u_angle,
    input  logic                    last_in,
    output logic                    gauss_valid,
    input  logic                    gauss_stall,
    output logic signed [OUT_W-1:0] gauss_sample,
    output logic                    last_out
);

    logic adv;

    assign adv       = !(gauss_valid && gauss_stall);
    assign uni_stall = !adv;

    // ---- leading-one detect and normalise 1 - u ----
    logic [X_W-1:0]          x;
    logic [P_W-1:0]          p;
    logic [X_W+MANT_W-2:0]   xs;
    log_t                    lod_next;
    side_t                   side_in;

    always_comb
    begin
        x = (X_W'(1) << UNIFORM_BITS) - {1'b0, u_radius};
        p = '0;
        for (int i = 0; i < X_W; i++)
        begin
            if (x[i])
            begin
                p = P_W'(i);
            end
        end
        xs            = {x, {(MANT_W-1){1'b0}}} >> p;
        lod_next.m    = xs[MANT_W-1:0];
        lod_next.frac = '0;
        lod_next.k    = K_W'(UNIFORM_BITS) - K_W'(p);
        side_in.ph    = u_angle;
        side_in.last  = last_in;
    end

    logic  log_valid [LOG_STEPS+1];
    log_t  log_d     [LOG_STEPS+1];
    side_t log_side  [LOG_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_valid[0] <= 1'b0;
        end
        else if (adv)
        begin
            log_valid[0] <= uni_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            log_d[0]    <= lod_next;
            log_side[0] <= side_in;
        end
    end

    for (genvar i = 0; i < LOG_STEPS; i++)
    begin : g_log
        bmg_log_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .src_valid (log_valid[i]),
            .src_log   (log_d[i]),
            .src_side  (log_side[i]),
            .dst_valid (log_valid[i+1]),
            .dst_log   (log_d[i+1]),
            .dst_side  (log_side[i+1])
        );
    end

    // ---- -2 ln(1-u) in Q.48 ----
    logic [N_W-1:0]    n_val;
    logic [N_W+31:0]   s_prod;
    sqrt_t             rad_next;

    always_comb
    begin
        n_val        = {log_d[LOG_STEPS].k, {LOG_FRAC{1'b0}}} - N_W'(log_d[LOG_STEPS].frac);
        s_prod       = n_val * TWO_LN2_Q31;
        rad_next.v   = V_W'(s_prod[N_W+31:7]);
        rad_next.rem = '0;
        rad_next.root = '0;
    end

    logic  sq_valid [SQRT_STEPS+1];
    sqrt_t sq_d     [SQRT_STEPS+1];
    side_t sq_side  [SQRT_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid[0] <= log_valid[LOG_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_d[0]    <= rad_next;
            sq_side[0] <= log_side[LOG_STEPS];
        end
    end

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        bmg_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .src_valid (sq_valid[i]),
            .src_sqrt  (sq_d[i]),
            .src_side  (sq_side[i]),
            .dst_valid (sq_valid[i+1]),
            .dst_sqrt  (sq_d[i+1]),
            .dst_side  (sq_side[i+1])
        );
    end

    // ---- angle fold into the first octant ----
    logic [Q_W-1:0] f_val;
    logic           swap_next;
    logic [Q_W-1:0] g_next;

    always_comb
    begin
        f_val     = sq_side[SQRT_STEPS].ph[Q_W-1:0];
        swap_next = f_val > (Q_W'(1) << (Q_W - 1));
        g_next    = swap_next ? Q_W'(ONE_Q30 - TRIG_W'(f_val)) : f_val;
    end

    logic           fold_valid_reg;
    logic [Q_W-1:0] fold_g_reg;
    logic [1:0]     fold_quad_reg;
    logic           fold_swap_reg;
    logic [R_W-1:0] fold_r_reg;
    logic           fold_last_reg;

    // theta and theta squared stages
    logic [Q_W+30:0] th_prod;
    logic            th_valid_reg;
    ang_t            th_ang_reg;
    logic [2*Q_W-1:0] t2_prod;
    logic            hv    [HORNER_STEPS+1];
    ang_t            h_ang [HORNER_STEPS+1];
    trig_t           h_trig[HORNER_STEPS+1];

    always_comb
    begin
        th_prod = fold_g_reg * HALF_PI_Q30;
        t2_prod = th_ang_reg.th * th_ang_reg.th;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
            th_valid_reg   <= 1'b0;
            hv[0]          <= 1'b0;
        end
        else if (adv)
        begin
            fold_valid_reg <= sq_valid[SQRT_STEPS];
            th_valid_reg   <= fold_valid_reg;
            hv[0]          <= th_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fold_g_reg      <= g_next;
            fold_quad_reg   <= sq_side[SQRT_STEPS].ph[31:30];
            fold_swap_reg   <= swap_next;
            fold_r_reg      <= sq_d[SQRT_STEPS].root;
            fold_last_reg   <= sq_side[SQRT_STEPS].last;
            th_ang_reg.th   <= th_prod[2*Q_W-1:Q_W];
            th_ang_reg.t2   <= '0;
            th_ang_reg.quad <= fold_quad_reg;
            th_ang_reg.swap <= fold_swap_reg;
            th_ang_reg.r    <= fold_r_reg;
            th_ang_reg.last <= fold_last_reg;
            h_ang[0]        <= '{th:   th_ang_reg.th,
                                 t2:   t2_prod[2*Q_W-1:Q_W],
                                 quad: th_ang_reg.quad,
                                 swap: th_ang_reg.swap,
                                 r:    th_ang_reg.r,
                                 last: th_ang_reg.last};
            h_trig[0]       <= '{s: ONE_Q30, c: ONE_Q30};
        end
    end

    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_horner
        bmg_horner_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .coef      (HORNER_K[i]),
            .src_valid (hv[i]),
            .src_ang   (h_ang[i]),
            .src_trig  (h_trig[i]),
            .dst_valid (hv[i+1]),
            .dst_ang   (h_ang[i+1]),
            .dst_trig  (h_trig[i+1])
        );
    end

    // ---- sine finish, quadrant select ----
    logic [Q_W+TRIG_W-1:0] sin_prod;
    logic [TRIG_W-1:0]     sin_q;
    logic [TRIG_W-1:0]     cq;
    logic [TRIG_W-1:0]     sq_mag;
    logic [TRIG_W-1:0]     mag_next;
    logic                  neg_next;

    always_comb
    begin
        sin_prod = h_ang[HORNER_STEPS].th * h_trig[HORNER_STEPS].s;
        sin_q    = TRIG_W'(sin_prod[2*Q_W-1:Q_W]);
        cq       = h_ang[HORNER_STEPS].swap ? sin_q : h_trig[HORNER_STEPS].c;
        sq_mag   = h_ang[HORNER_STEPS].swap ? h_trig[HORNER_STEPS].c : sin_q;
        case (h_ang[HORNER_STEPS].quad)
            2'd0:
            begin
                mag_next = cq;
                neg_next = 1'b0;
            end
            2'd1:
            begin
                mag_next = sq_mag;
                neg_next = 1'b1;
            end
            2'd2:
            begin
                mag_next = cq;
                neg_next = 1'b1;
            end
            default:
            begin
                mag_next = sq_mag;
                neg_next = 1'b0;
            end
        endcase
        if (mag_next == '0)
        begin
            neg_next = 1'b0;
        end
    end

    logic              trig_valid_reg;
    logic [TRIG_W-1:0] trig_mag_reg;
    logic              trig_neg_reg;
    logic [R_W-1:0]    trig_r_reg;
    logic              trig_last_reg;

    logic              prod_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              prod_neg_reg;
    logic              prod_last_reg;

    // ---- round to nearest, saturate, apply sign ----
    logic [PROD_W:0]    rnd_sum;
    logic [MAG_W-1:0]   rnd_mag;
    logic [MAG_W-1:0]   sat_mag;
    logic [OUT_W-1:0]   sample_next;

    always_comb
    begin
        rnd_sum = {1'b0, prod_reg} + ((PROD_W+1)'(1) << (ROUND_SH - 1));
        rnd_mag = rnd_sum[PROD_W:ROUND_SH];
        if (prod_neg_reg)
        begin
            sat_mag     = (rnd_mag > SAT_LIM) ? SAT_LIM : rnd_mag;
            sample_next = OUT_W'(MAG_W'(0) - sat_mag);
        end
        else
        begin
            sat_mag     = (rnd_mag > SAT_LIM - MAG_W'(1)) ? SAT_LIM - MAG_W'(1) : rnd_mag;
            sample_next = OUT_W'(sat_mag);
        end
    end

    logic             out_valid_reg;
    logic [OUT_W-1:0] sample_reg;
    logic             last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            trig_valid_reg <= hv[HORNER_STEPS];
            prod_valid_reg <= trig_valid_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trig_mag_reg  <= mag_next;
            trig_neg_reg  <= neg_next;
            trig_r_reg    <= h_ang[HORNER_STEPS].r;
            trig_last_reg <= h_ang[HORNER_STEPS].last;
            prod_reg      <= trig_r_reg * trig_mag_reg;
            prod_neg_reg  <= trig_neg_reg;
            prod_last_reg <= trig_last_reg;
            sample_reg    <= sample_next;
            last_reg      <= prod_last_reg;
        end
    end

    assign gauss_valid  = out_valid_reg;
    assign gauss_sample = signed'(sample_reg);
    assign last_out     = last_reg;

`ifndef ASSERT_OFF
    // a zero cosine/sine magnitude never carries a minus sign
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        trig_valid_reg && trig_mag_reg == '0 |-> !trig_neg_reg)
        else $error("negative zero trig magnitude");
    // a held output keeps the whole chain frozen
    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        gauss_valid && gauss_stall |=> $stable(prod_reg) && $stable(trig_mag_reg))
        else $error("chain moved while output held");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the Box-Muller Gaussian transform unit: scoreboard, drivers and checks.
module tb;
    import bmg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 70;

    int mismatches = 0;

    task automatic report(input string what);
        mismatches++;
        $display("MISMATCH %s", what);
    endtask

    typedef struct {
        logic signed [OUT_W-1:0] sample;
        logic                    last;
    } gauss_exp_t;

    class gauss_scoreboard;
        gauss_exp_t pending[$];

        // floor sqrt, bit by bit
        function automatic longint unsigned int_sqrt(input longint unsigned v);
            longint unsigned res = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function automatic longint unsigned radius_q24(input logic [31:0] u);
            longint unsigned x = (64'd1 << 32) - {32'd0, u};
            longint unsigned m;
            longint unsigned frac = 0;
            longint unsigned n;
            int p = 63;
            while (p > 0 && x[p] == 1'b0) p--;
            m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
            for (int i = 23; i >= 0; i--)
            begin
                m = (m * m) >> 31;
                if (m >= (64'd1 << 32))
                begin
                    m >>= 1;
                    frac |= 64'd1 << i;
                end
            end
            n = (longint'(32 - p) << 24) - frac;
            return int_sqrt((n * 64'hB17217F8) >> 7);
        endfunction

        function automatic longint unsigned poly_step(input longint unsigned t2,
                input longint unsigned acc, input longint unsigned k);
            return (64'd1 << 30) - ((t2 * acc) >> 30) / k;
        endfunction

        function automatic longint unsigned cos_mag(input logic [31:0] ph, output bit neg);
            longint unsigned one = 64'd1 << 30;
            longint unsigned f = ph[29:0];
            longint unsigned g, th, t2, s, c, mag;
            bit swp = 0;
            if (f > (64'd1 << 29))
            begin
                g = one - f;
                swp = 1;
            end
            else
                g = f;
            th = (g * 64'd1686629713) >> 30;
            t2 = (th * th) >> 30;
            s = poly_step(t2, one, 110);
            s = poly_step(t2, s, 72);
            s = poly_step(t2, s, 42);
            s = poly_step(t2, s, 20);
            s = poly_step(t2, s, 6);
            s = (th * s) >> 30;
            c = poly_step(t2, one, 90);
            c = poly_step(t2, c, 56);
            c = poly_step(t2, c, 30);
            c = poly_step(t2, c, 12);
            c = poly_step(t2, c, 2);
            case (ph[31:30])
                2'd0: begin mag = swp ? s : c; neg = 0; end
                2'd1: begin mag = swp ? c : s; neg = 1; end
                2'd2: begin mag = swp ? s : c; neg = 1; end
                default: begin mag = swp ? c : s; neg = 0; end
            endcase
            if (mag == 0) neg = 0;
            return mag;
        endfunction

        function void note_input(input logic [31:0] ur, input logic [31:0] ua, input logic lst);
            gauss_exp_t e;
            bit neg;
            longint unsigned prod, mag;
            longint unsigned lim = 64'd1 << (FRAC_BITS + 3);
            int sh = 54 - FRAC_BITS;
            prod = radius_q24(ur) * cos_mag(ua, neg);
            mag = (prod + (64'd1 << (sh - 1))) >> sh;
            if (neg)
            begin
                if (mag > lim) mag = lim;
                e.sample = OUT_W'(64'd0 - mag);
            end
            else
            begin
                if (mag > lim - 1) mag = lim - 1;
                e.sample = OUT_W'(mag);
            end
            e.last = lst;
            pending = {pending, e};
        endfunction

        task check_result(input logic signed [OUT_W-1:0] smp, input logic lst);
            gauss_exp_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected beat sample=%0d last=%0b", smp, lst));
                return;
            end
            e = pending.pop_front();
            if (smp !== e.sample)
                report($sformatf("sample got %0d exp %0d", smp, e.sample));
            if (lst !== e.last)
                report($sformatf("last got %0b exp %0b", lst, e.last));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic uni_valid = 0;
    logic uni_stall;
    logic [31:0] u_radius = '0;
    logic [31:0] u_angle = '0;
    logic last_in = 0;
    logic gauss_valid;
    logic gauss_stall = 0;
    logic signed [OUT_W-1:0] gauss_sample;
    logic last_out;

    gauss_scoreboard sb = new();
    bit hold_rx = 0;
    bit rx_random = 0;

    box_muller_gaussian_transform_unit dut (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one beat and wait for it to be taken
    task automatic send_beat(input logic [31:0] ur, input logic [31:0] ua, input logic lst);
        u_radius <= ur;
        u_angle <= ua;
        last_in <= lst;
        uni_valid <= 1;
        do @(posedge clk); while (uni_stall);
        sb.note_input(ur, ua, lst);
    endtask

    task automatic idle_sender(input int n);
        if (n == 0) return;
        uni_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15);
            1: return 32'hFFFFFFFF - $urandom_range(0, 15);
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, or held off while hold_rx is set
    always @(posedge clk)
    begin
        if (gauss_valid && !gauss_stall)
            sb.check_result(gauss_sample, last_out);
        if (hold_rx)
            gauss_stall <= 1;
        else if (rx_random)
            gauss_stall <= ($urandom_range(0, 99) < 25);
        else
            gauss_stall <= 0;
    end

    initial
    begin
        logic [31:0] dir_r[] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000,
                                 32'h7FFFFFFF, 32'hC0000000, 32'hAAAAAAAA, 32'h55555555};
        logic [31:0] dir_a[] = '{32'h0, 32'h40000000, 32'h80000000, 32'hC0000000,
                                 32'h20000000, 32'h20000001, 32'h3FFFFFFF, 32'hFFFFFFFF,
                                 32'h60000000, 32'hE0000001};
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: radius extremes against quadrant and fold points
        foreach (dir_r[i])
            send_beat(dir_r[i], dir_a[i % dir_a.size()], i[0]);
        foreach (dir_a[i])
            send_beat(32'hFFFFFFFF, dir_a[i], ~i[0]);
        idle_sender(1);
        rx_random = 1;
        for (int n = 0; n < 1950; n++)
        begin
            if (n == 400)
            begin
                // long receiver hold-off while the sender keeps offering
                hold_rx = 1;
                fork
                    begin
                        repeat (150) @(posedge clk);
                        hold_rx = 0;
                    end
                join_none
            end
            if (n == 1000)
            begin
                uni_valid <= 0;
                while (sb.pending.size() != 0) @(posedge clk);
            end
            if (n > 1500 && n < 1700)
                send_beat($urandom, $urandom, $urandom_range(0, 1));
            else
            begin
                send_beat(rand_word(), rand_word(), $urandom_range(0, 1));
                idle_sender(gap_len());
            end
        end
        uni_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("box_muller_gaussian_transform_unit regression: pass");
        else
            $display("box_muller_gaussian_transform_unit regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("box_muller_gaussian_transform_unit regression: fail");
        $finish;
    end
endmodule
